### rtl/core/chm_pkg.sv
// shared types and constants for the chained hash multiset core
// no dependencies
package chm_pkg;

  localparam int unsigned KEY_W = 31;
  localparam int unsigned CMD_W = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] key;
  } chm_req_t;

  typedef struct packed {
    logic found;
    logic status;
  } chm_rsp_t;

endpackage

### rtl/core/chm_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module chm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/core/chm_mod.sv
// key modulo bucket count by reciprocal multiplication, pipelined through quotient, difference and remainder registers
// depends on chm_pkg
module chm_mod
  import chm_pkg::*;
#(
  parameter int unsigned BUCKET_COUNT = 1021
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [KEY_W-1:0]                key_i,
  output logic                            done_o,
  output logic [$clog2(BUCKET_COUNT)-1:0] rem_o
);

  localparam int unsigned BAW = $clog2(BUCKET_COUNT);
  localparam int unsigned RW  = BAW + 1;
  localparam int unsigned PRW = KEY_W + 32;
  localparam int unsigned QDW = KEY_W + BAW;
  // floor(2^32 / BUCKET_COUNT); the quotient estimate is low by at most one
  localparam logic [63:0] RECIP64 = (64'd1 << 32) / 64'(BUCKET_COUNT);
  localparam logic [31:0] RECIP   = RECIP64[31:0];

  logic [KEY_W-1:0] key_q;
  logic [KEY_W-1:0] quo_q, quo_d;
  logic [RW-1:0]    diff_q, diff_d;
  logic [RW-1:0]    rem_q, rem_d;
  logic [PRW-1:0]   prod;
  logic [QDW-1:0]   back;
  logic [KEY_W-1:0] sub;
  logic             go_q, quo_vld_q, diff_vld_q, done_q;

  assign prod  = PRW'(key_q) * PRW'(RECIP);
  assign quo_d = prod[PRW-1:32];
  assign back  = QDW'(quo_q) * QDW'(BUCKET_COUNT);
  // key minus estimated quotient times bucket count lies below twice the count
  assign sub    = key_q - back[KEY_W-1:0];
  assign diff_d = sub[RW-1:0];
  assign rem_d  = (diff_q >= RW'(BUCKET_COUNT)) ? diff_q - RW'(BUCKET_COUNT) : diff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      go_q       <= 1'b0;
      quo_vld_q  <= 1'b0;
      diff_vld_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      go_q       <= start_i;
      quo_vld_q  <= go_q;
      diff_vld_q <= quo_vld_q;
      done_q     <= diff_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      key_q <= key_i;
    end
    quo_q  <= quo_d;
    diff_q <= diff_d;
    rem_q  <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[RW-2:0];

endmodule

### rtl/core/chained_hash_multiset_core.sv
// chained hash multiset: bucket chains in a node pool with a free list
// depends on chm_pkg, chm_ram, chm_mod
//
//   channel  | dir | handshake             | payload
//   request  | in  | in_valid_i/in_stall_o | in_req_i (command, key)
//   response | out | out_valid_o/out_stall_i | out_rsp_o (found, status)
//
// one request at a time; the bucket hash keeps it in the hash state until the remainder is done
// insert takes a free node and links it behind the tail if the bucket has one, or is
// refused; query walks the chain node by node, delete frees the node on removal
// after reset a clearing pass over all buckets and pool entries builds
// the free list and empties the buckets; requests wait during it
// a waiting response holds the next result back but not the next request
module chained_hash_multiset_core
  import chm_pkg::*;
#(
  parameter int unsigned BUCKET_COUNT = 1021,
  parameter int unsigned POOL_ENTRIES = 4096
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  chm_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output chm_rsp_t out_rsp_o
);

  localparam int unsigned PW  = $clog2(POOL_ENTRIES + 1);
  localparam int unsigned IW  = $clog2(POOL_ENTRIES);
  localparam int unsigned BAW = $clog2(BUCKET_COUNT);
  localparam int unsigned CLR = (BUCKET_COUNT > POOL_ENTRIES) ? BUCKET_COUNT : POOL_ENTRIES;
  localparam int unsigned CW  = $clog2(CLR);
  localparam logic [PW-1:0] NIL = PW'(POOL_ENTRIES);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_HASH  = 9'b000000100,
    S_BKT   = 9'b000001000,
    S_INS   = 9'b000010000,
    S_LINK  = 9'b000100000,
    S_WALK  = 9'b001000000,
    S_FREE  = 9'b010000000,
    S_RESP  = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0]    clr_q, clr_d;
  logic [CMD_W-1:0] cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [BAW-1:0]   bkt_q, bkt_d;
  logic [PW-1:0]    head_q, head_d, tail_q, tail_d;
  logic [PW-1:0]    cur_q, cur_d, prev_q, prev_d;
  logic [PW-1:0]    free_head_q, free_head_d;
  logic             res_found_q, res_found_d, res_status_q, res_status_d;
  logic             out_valid_q, out_valid_d;
  chm_rsp_t         out_q, out_d;
  logic             accept;

  logic              bkt_we;
  logic [BAW-1:0]    bkt_waddr, bkt_raddr;
  logic [2*PW-1:0]   bkt_wdata, bkt_rdata;
  logic              nxt_we;
  logic [IW-1:0]     nxt_waddr, nxt_raddr;
  logic [PW-1:0]     nxt_wdata, nxt_rdata;
  logic              key_we;
  logic [IW-1:0]     key_waddr, key_raddr;
  logic [KEY_W-1:0]  key_wdata, key_rdata;
  logic              mod_done;
  logic [BAW-1:0]    mod_rem;

  chm_ram #(.WIDTH(2*PW), .DEPTH(BUCKET_COUNT)) u_bkt_ram (
    .clk_i, .we_i(bkt_we), .waddr_i(bkt_waddr), .wdata_i(bkt_wdata),
    .raddr_i(bkt_raddr), .rdata_o(bkt_rdata)
  );

  chm_ram #(.WIDTH(PW), .DEPTH(POOL_ENTRIES)) u_next_ram (
    .clk_i, .we_i(nxt_we), .waddr_i(nxt_waddr), .wdata_i(nxt_wdata),
    .raddr_i(nxt_raddr), .rdata_o(nxt_rdata)
  );

  chm_ram #(.WIDTH(KEY_W), .DEPTH(POOL_ENTRIES)) u_key_ram (
    .clk_i, .we_i(key_we), .waddr_i(key_waddr), .wdata_i(key_wdata),
    .raddr_i(key_raddr), .rdata_o(key_rdata)
  );

  chm_mod #(.BUCKET_COUNT(BUCKET_COUNT)) u_mod (
    .clk_i, .rst_ni, .start_i(accept), .key_i(in_req_i.key),
    .done_o(mod_done), .rem_o(mod_rem)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    bkt_d        = bkt_q;
    head_d       = head_q;
    tail_d       = tail_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    free_head_d  = free_head_q;
    res_found_d  = res_found_q;
    res_status_d = res_status_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    bkt_we    = 1'b0;
    bkt_waddr = bkt_q;
    bkt_wdata = {head_q, tail_q};
    bkt_raddr = bkt_q;
    nxt_we    = 1'b0;
    nxt_waddr = cur_q[IW-1:0];
    nxt_wdata = NIL;
    nxt_raddr = cur_q[IW-1:0];
    key_we    = 1'b0;
    key_waddr = cur_q[IW-1:0];
    key_wdata = key_q;
    key_raddr = cur_q[IW-1:0];

    case (state_q)
      S_CLEAR: begin
        // empty every bucket and chain the pool into the free list
        if (32'(clr_q) < BUCKET_COUNT) begin
          bkt_we    = 1'b1;
          bkt_waddr = clr_q[BAW-1:0];
          bkt_wdata = {NIL, NIL};
        end
        if (32'(clr_q) < POOL_ENTRIES) begin
          nxt_we    = 1'b1;
          nxt_waddr = clr_q[IW-1:0];
          nxt_wdata = PW'(clr_q) + PW'(1);
        end
        clr_d = clr_q + CW'(1);
        if (32'(clr_q) == CLR - 1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          res_found_d  = 1'b0;
          res_status_d = 1'b0;
          state_d      = S_HASH;
        end
      end
      S_HASH: begin
        if (mod_done) begin
          bkt_d     = mod_rem;
          bkt_raddr = mod_rem;
          if (cmd_q == CMD_INSERT || cmd_q == CMD_DELETE || cmd_q == CMD_QUERY) begin
            state_d = S_BKT;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_BKT: begin
        head_d = bkt_rdata[2*PW-1:PW];
        tail_d = bkt_rdata[PW-1:0];
        if (cmd_q == CMD_INSERT) begin
          if (free_head_q >= NIL) begin
            res_status_d = 1'b1;
            state_d      = S_RESP;
          end else begin
            nxt_raddr = free_head_q[IW-1:0];
            state_d   = S_INS;
          end
        end else if (bkt_rdata[2*PW-1:PW] >= NIL) begin
          state_d = S_RESP;
        end else begin
          nxt_raddr = bkt_rdata[PW+IW-1:PW];
          key_raddr = bkt_rdata[PW+IW-1:PW];
          cur_d     = bkt_rdata[2*PW-1:PW];
          prev_d    = NIL;
          state_d   = S_WALK;
        end
      end
      S_INS: begin
        free_head_d = nxt_rdata;
        cur_d       = free_head_q;
        key_we      = 1'b1;
        key_waddr   = free_head_q[IW-1:0];
        nxt_we      = 1'b1;
        nxt_waddr   = free_head_q[IW-1:0];
        nxt_wdata   = NIL;
        bkt_we      = 1'b1;
        if (head_q < NIL && tail_q < NIL) begin
          bkt_wdata = {head_q, free_head_q};
          state_d   = S_LINK;
        end else begin
          bkt_wdata = {free_head_q, free_head_q};
          state_d   = S_RESP;
        end
      end
      S_LINK: begin
        nxt_we    = 1'b1;
        nxt_waddr = tail_q[IW-1:0];
        nxt_wdata = cur_q;
        state_d   = S_RESP;
      end
      S_WALK: begin
        if (key_rdata == key_q) begin
          res_found_d = 1'b1;
          if (cmd_q == CMD_DELETE) begin
            // unlink: predecessor or bucket head takes the successor
            if (prev_q < NIL) begin
              nxt_we    = 1'b1;
              nxt_waddr = prev_q[IW-1:0];
              nxt_wdata = nxt_rdata;
            end
            bkt_we    = 1'b1;
            bkt_wdata = {(prev_q < NIL) ? head_q : nxt_rdata,
                         (tail_q == cur_q) ? prev_q : tail_q};
            state_d   = S_FREE;
          end else begin
            state_d = S_RESP;
          end
        end else if (nxt_rdata >= NIL) begin
          state_d = S_RESP;
        end else begin
          prev_d    = cur_q;
          cur_d     = nxt_rdata;
          nxt_raddr = nxt_rdata[IW-1:0];
          key_raddr = nxt_rdata[IW-1:0];
        end
      end
      S_FREE: begin
        nxt_we      = 1'b1;
        nxt_waddr   = cur_q[IW-1:0];
        nxt_wdata   = free_head_q;
        free_head_d = cur_q;
        state_d     = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.found  = res_found_q;
          out_d.status = res_status_q;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      free_head_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      free_head_q <= free_head_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= in_req_i.command;
      key_q <= in_req_i.key;
    end
    bkt_q        <= bkt_d;
    head_q       <= head_d;
    tail_q       <= tail_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    res_found_q  <= res_found_d;
    res_status_q <= res_status_d;
    out_q        <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef NO_ASSERTIONS
  a_hash_done_in_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> state_q == S_HASH)
    else $error("hash result outside hash state");

  a_refuse_only_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && res_status_q) |-> cmd_q == CMD_INSERT)
    else $error("pool full flag on non insert");

  a_insert_has_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INS |-> free_head_q < NIL)
    else $error("insert without free node");

  a_resp_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && !out_valid_q) |=> out_valid_q && state_q == S_IDLE)
    else $error("response not delivered");
`endif

endmodule
